// ===== rtl/psrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrm_pkg
// Shared widths, constants and helper functions for the pitched sample
// resample mixer: field widths, the semitone ratio table and gain constants.
// ----------------------------------------------------------------------------
package psrm_pkg;

  // Source memory geometry.
  localparam int SOURCE_DEPTH = 65536;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ADDR_W       = $clog2(SOURCE_DEPTH);
  localparam int BANK_DEPTH   = SOURCE_DEPTH / 2;
  localparam int BANK_AW      = ADDR_W - 1;

  // Port field widths.
  localparam int LEN_W    = 17;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 16;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int START_W  = 24;
  localparam int OFFS_W   = 21;
  localparam int MIX_W    = 24;
  localparam int TARGET_W = 25;

  // Read position arithmetic.
  localparam int RATIO_W          = 17;
  localparam int PROD_W           = OFFS_W + RATIO_W;
  localparam int OCT_W            = 4;
  localparam int SEMI_W           = 4;
  localparam int MAX_OCTAVE       = 10;
  localparam int NOTES_PER_OCTAVE = 12;
  localparam int SHIFT_W          = PROD_W + MAX_OCTAVE;
  localparam int POS_LSB          = 5;
  localparam int FRAC_W           = 16;
  localparam int IDX_LSB          = POS_LSB + FRAC_W;
  localparam int IDX_W            = SHIFT_W - IDX_LSB;

  // Interpolation and gain arithmetic.
  localparam int DIFF_W      = SAMPLE_WIDTH + 1;
  localparam int FMUL_W      = DIFF_W + FRAC_W + 1;
  localparam int V_W         = FMUL_W;
  localparam int P_W         = V_W + VEL_W + 1;
  localparam int X_W         = 22;
  localparam int RECIP_W     = 23;
  localparam int QP_W        = X_W + RECIP_W;
  localparam int RECIP_SHIFT = 30;
  localparam int Q_W         = 15;
  localparam int ADD_W       = Q_W + 1;
  localparam int SUM_W       = MIX_W + 1;

  // Gain is velocity / (254 * 2^16); half the divisor gives round to nearest.
  localparam int GAIN_STEPS = 254;
  localparam logic [P_W-1:0] GAIN_HALF = P_W'((GAIN_STEPS / 2) * (1 << FRAC_W));
  // ceil(2^30 / 254): exact floor division for any dividend below 2^22.
  localparam logic [RECIP_W-1:0] RECIP_MAGIC = RECIP_W'(4227331);

  // Semitone ratio 2^(k/12) in Q16, rounded to nearest.
  function automatic logic [RATIO_W-1:0] semi_ratio(input logic [SEMI_W-1:0] k);
    logic [RATIO_W-1:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // Octave of a note: count of whole octaves contained in the note number.
  function automatic logic [OCT_W-1:0] note_octave(input logic [NOTE_W-1:0] note);
    logic [OCT_W-1:0] oct;
    oct = '0;
    for (int i = 1; i <= MAX_OCTAVE; i++) begin
      if (32'(note) >= 32'(i * NOTES_PER_OCTAVE)) oct = oct + OCT_W'(1);
    end
    return oct;
  endfunction

  // Semitone within the octave.
  function automatic logic [SEMI_W-1:0] note_semitone(input logic [NOTE_W-1:0] note,
                                                      input logic [OCT_W-1:0]  oct);
    logic [NOTE_W-1:0] rem;
    rem = note - NOTE_W'(oct) * NOTE_W'(NOTES_PER_OCTAVE);
    return rem[SEMI_W-1:0];
  endfunction

endpackage

// ===== rtl/psrm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrm_in_if
// Request channel: load and render items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface psrm_in_if
  import psrm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [INDEX_W-1:0]         source_index;
  logic signed [VALUE_W-1:0]  source_value;
  logic [NOTE_W-1:0]          pitch_note;
  logic [VEL_W-1:0]           velocity;
  logic [START_W-1:0]         start_position;
  logic [OFFS_W-1:0]          sample_offset;
  logic signed [MIX_W-1:0]    mix_in;

  modport source (
    output valid, req_type, source_index, source_value, pitch_note, velocity,
           start_position, sample_offset, mix_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, source_index, source_value, pitch_note, velocity,
           start_position, sample_offset, mix_in,
    output ready
  );
endinterface

// ===== rtl/psrm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrm_out_if
// Result channel: one mixed output sample per render item.
// ----------------------------------------------------------------------------
interface psrm_out_if
  import psrm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [TARGET_W-1:0]      target_index;
  logic signed [MIX_W-1:0]  mix_out;
  logic                     in_range;
  logic                     saturated;

  modport source (
    output valid, target_index, mix_out, in_range, saturated,
    input  ready
  );

  modport sink (
    input  valid, target_index, mix_out, in_range, saturated,
    output ready
  );
endinterface

// ===== rtl/psrm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read and a read enable that holds the output.
// ----------------------------------------------------------------------------
module psrm_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pitched_sample_resample_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitched_sample_resample_mixer_core
// Sample-playback voice: load items fill a banked source-sample memory,
// render items resample it by a note-dependent ratio with linear
// interpolation, scale by velocity and add into a saturating mix value.
//
// A render item passes through stage registers a, b, c, d, e, f, g, h and o.
// Throughput: one item per cycle; the nine-stage pipeline only stalls when
// the output is held and every stage is full. Both interpolation taps are
// read together from an even bank and an odd bank of the source memory.
// Reset clears all pipeline valid bits and the source length register; the
// source memory is not cleared and holds undefined data until loaded.
// ----------------------------------------------------------------------------
module pitched_sample_resample_mixer_core
  import psrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  psrm_in_if.sink          in_ch,
  psrm_out_if.source       out_ch
);

  // Pipeline stage contents.
  typedef struct packed {
    logic                       render;
    logic [INDEX_W-1:0]         src_index;
    logic signed [VALUE_W-1:0]  src_value;
    logic [NOTE_W-1:0]          note;
    logic [VEL_W-1:0]           vel;
    logic [START_W-1:0]         start;
    logic [OFFS_W-1:0]          offs;
    logic signed [MIX_W-1:0]    mix;
  } a_t;

  typedef struct packed {
    logic                          render;
    logic [ADDR_W-1:0]             ld_addr;
    logic [SAMPLE_WIDTH-1:0]       ld_value;
    logic [PROD_W-1:0]             prod;
    logic [OCT_W-1:0]              oct;
    logic [VEL_W-1:0]              vel;
    logic signed [MIX_W-1:0]       mix;
    logic [TARGET_W-1:0]           target;
  } b_t;

  typedef struct packed {
    logic                     odd;
    logic [FRAC_W-1:0]        frac;
    logic [VEL_W-1:0]         vel;
    logic signed [MIX_W-1:0]  mix;
    logic [TARGET_W-1:0]      target;
    logic                     inr;
  } c_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] s1;
    logic signed [FMUL_W-1:0]       fmul;
    logic [VEL_W-1:0]               vel;
    logic signed [MIX_W-1:0]        mix;
    logic [TARGET_W-1:0]            target;
    logic                           inr;
  } d_t;

  typedef struct packed {
    logic signed [V_W-1:0]    v;
    logic [VEL_W-1:0]         vel;
    logic signed [MIX_W-1:0]  mix;
    logic [TARGET_W-1:0]      target;
    logic                     inr;
  } e_t;

  typedef struct packed {
    logic signed [P_W-1:0]    p;
    logic signed [MIX_W-1:0]  mix;
    logic [TARGET_W-1:0]      target;
    logic                     inr;
  } f_t;

  typedef struct packed {
    logic [X_W-1:0]           x;
    logic                     neg;
    logic signed [MIX_W-1:0]  mix;
    logic [TARGET_W-1:0]      target;
    logic                     inr;
  } g_t;

  typedef struct packed {
    logic [QP_W-1:0]          qp;
    logic                     neg;
    logic signed [MIX_W-1:0]  mix;
    logic [TARGET_W-1:0]      target;
    logic                     inr;
  } h_t;

  typedef struct packed {
    logic [TARGET_W-1:0]      target;
    logic signed [MIX_W-1:0]  mix;
    logic                     inr;
    logic                     sat;
  } o_t;

  logic [LEN_W-1:0] len_r, len_nxt;

  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, h_v_r, o_v_r;
  logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_f, adv_g, adv_h, adv_o;

  a_t a_r, a_nxt;
  b_t b_r, b_nxt;
  c_t c_r, c_nxt;
  d_t d_r, d_nxt;
  e_t e_r, e_nxt;
  f_t f_r, f_nxt;
  g_t g_r, g_nxt;
  h_t h_r, h_nxt;
  o_t o_r, o_nxt;

  // Source length register, capped to the memory depth on write.
  always_comb begin
    len_nxt = len_r;
    if (cfg_we) begin
      if (cfg_wdata > LEN_W'(SOURCE_DEPTH)) len_nxt = LEN_W'(SOURCE_DEPTH);
      else                                  len_nxt = cfg_wdata;
    end
  end

  // Each stage loads when it is empty or its content moves on.
  assign adv_o = !o_v_r || out_ch.ready;
  assign adv_h = !h_v_r || adv_o;
  assign adv_g = !g_v_r || adv_h;
  assign adv_f = !f_v_r || adv_g;
  assign adv_e = !e_v_r || adv_f;
  assign adv_d = !d_v_r || adv_e;
  assign adv_c = !c_v_r || adv_d;
  assign adv_b = !b_v_r || adv_c;
  assign adv_a = !a_v_r || adv_b;

  assign in_ch.ready = adv_a;

  // Capture the transfer.
  always_comb begin
    a_nxt.render    = in_ch.req_type;
    a_nxt.src_index = in_ch.source_index;
    a_nxt.src_value = in_ch.source_value;
    a_nxt.note      = in_ch.pitch_note;
    a_nxt.vel       = in_ch.velocity;
    a_nxt.start     = in_ch.start_position;
    a_nxt.offs      = in_ch.sample_offset;
    a_nxt.mix       = in_ch.mix_in;
  end

  // Offset times semitone ratio, octave split and target position.
  logic [OCT_W-1:0]  a_oct;
  logic [SEMI_W-1:0] a_semi;

  always_comb begin
    a_oct          = note_octave(a_r.note);
    a_semi         = note_semitone(a_r.note, a_oct);
    b_nxt.render   = a_r.render;
    b_nxt.ld_addr  = ADDR_W'(a_r.src_index);
    b_nxt.ld_value = SAMPLE_WIDTH'(a_r.src_value);
    b_nxt.prod     = PROD_W'(a_r.offs) * PROD_W'(semi_ratio(a_semi));
    b_nxt.oct      = a_oct;
    b_nxt.vel      = a_r.vel;
    b_nxt.mix      = a_r.mix;
    b_nxt.target   = TARGET_W'(a_r.start) + TARGET_W'(a_r.offs);
  end

  // Octave shift, index and fraction, range check and memory addresses.
  logic [SHIFT_W-1:0] b_shift;
  logic [IDX_W-1:0]   b_idx;
  logic [LEN_W-1:0]   b_next_idx;
  logic [BANK_AW-1:0] b_even_addr;
  logic [BANK_AW-1:0] b_odd_addr;
  logic               b_load_we;

  always_comb begin
    b_shift      = SHIFT_W'(b_r.prod) << b_r.oct;
    b_idx        = b_shift[SHIFT_W-1:IDX_LSB];
    b_next_idx   = LEN_W'(b_idx[ADDR_W-1:0]) + LEN_W'(1);
    b_odd_addr   = b_idx[ADDR_W-1:1];
    b_even_addr  = b_idx[ADDR_W-1:1] + BANK_AW'(b_idx[0]);
    b_load_we    = adv_c && b_v_r && !b_r.render;

    c_nxt.odd    = b_idx[0];
    c_nxt.frac   = b_shift[IDX_LSB-1:POS_LSB];
    c_nxt.vel    = b_r.vel;
    c_nxt.mix    = b_r.mix;
    c_nxt.target = b_r.target;
    c_nxt.inr    = (b_idx[IDX_W-1:ADDR_W] == '0) && (b_next_idx < len_r);
  end

  // Source memory split into even and odd frames, so both taps read at once.
  logic [SAMPLE_WIDTH-1:0] even_q;
  logic [SAMPLE_WIDTH-1:0] odd_q;

  psrm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (b_load_we && !b_r.ld_addr[0]),
    .waddr (b_r.ld_addr[ADDR_W-1:1]),
    .wdata (b_r.ld_value),
    .re    (adv_c),
    .raddr (b_even_addr),
    .rdata (even_q)
  );

  psrm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (b_load_we && b_r.ld_addr[0]),
    .waddr (b_r.ld_addr[ADDR_W-1:1]),
    .wdata (b_r.ld_value),
    .re    (adv_c),
    .raddr (b_odd_addr),
    .rdata (odd_q)
  );

  // Tap select and fractional step: (s2 - s1) * frac.
  logic signed [SAMPLE_WIDTH-1:0] c_s1;
  logic signed [SAMPLE_WIDTH-1:0] c_s2;
  logic signed [DIFF_W-1:0]       c_diff;
  logic signed [FRAC_W:0]         c_frac_s;

  always_comb begin
    c_s1         = c_r.odd ? odd_q : even_q;
    c_s2         = c_r.odd ? even_q : odd_q;
    c_diff       = DIFF_W'(c_s2) - DIFF_W'(c_s1);
    c_frac_s     = {1'b0, c_r.frac};
    d_nxt.s1     = c_s1;
    d_nxt.fmul   = c_diff * c_frac_s;
    d_nxt.vel    = c_r.vel;
    d_nxt.mix    = c_r.mix;
    d_nxt.target = c_r.target;
    d_nxt.inr    = c_r.inr;
  end

  // Interpolated value: s1 * 2^16 + (s2 - s1) * frac.
  always_comb begin
    e_nxt.v      = (V_W'(d_r.s1) <<< FRAC_W) + V_W'(d_r.fmul);
    e_nxt.vel    = d_r.vel;
    e_nxt.mix    = d_r.mix;
    e_nxt.target = d_r.target;
    e_nxt.inr    = d_r.inr;
  end

  // Velocity scaling.
  logic signed [VEL_W:0] e_vel_s;

  always_comb begin
    e_vel_s      = {1'b0, e_r.vel};
    f_nxt.p      = e_r.v * e_vel_s;
    f_nxt.mix    = e_r.mix;
    f_nxt.target = e_r.target;
    f_nxt.inr    = e_r.inr;
  end

  // Magnitude plus half divisor, then drop the 2^16 part of the divisor.
  logic [P_W-1:0] f_mag;
  logic [P_W-1:0] f_rnd;

  always_comb begin
    f_mag        = f_r.p[P_W-1] ? P_W'(-f_r.p) : P_W'(f_r.p);
    f_rnd        = f_mag + GAIN_HALF;
    g_nxt.x      = f_rnd[FRAC_W +: X_W];
    g_nxt.neg    = f_r.p[P_W-1];
    g_nxt.mix    = f_r.mix;
    g_nxt.target = f_r.target;
    g_nxt.inr    = f_r.inr;
  end

  // Divide by 254 through a reciprocal multiply.
  always_comb begin
    h_nxt.qp     = QP_W'(g_r.x) * QP_W'(RECIP_MAGIC);
    h_nxt.neg    = g_r.neg;
    h_nxt.mix    = g_r.mix;
    h_nxt.target = g_r.target;
    h_nxt.inr    = g_r.inr;
  end

  // Signed contribution, mix sum and saturation.
  logic [Q_W-1:0]           h_q;
  logic signed [ADD_W-1:0]  h_add;
  logic signed [SUM_W-1:0]  h_sum;

  always_comb begin
    h_q      = h_r.qp[RECIP_SHIFT +: Q_W];
    h_add    = h_r.neg ? -ADD_W'(h_q) : ADD_W'(h_q);
    h_sum    = SUM_W'(h_r.mix) + SUM_W'(h_add);
    o_nxt.target = h_r.target;
    o_nxt.inr    = h_r.inr;
    o_nxt.sat    = 1'b0;
    o_nxt.mix    = h_r.mix;
    if (h_r.inr) begin
      if (h_sum[SUM_W-1] != h_sum[SUM_W-2]) begin
        o_nxt.sat = 1'b1;
        o_nxt.mix = h_sum[SUM_W-1] ? {1'b1, {(MIX_W-1){1'b0}}}
                                   : {1'b0, {(MIX_W-1){1'b1}}};
      end else begin
        o_nxt.mix = h_sum[MIX_W-1:0];
      end
    end
  end

  // Control state: valid bits and the length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      if (adv_a) a_v_r <= in_ch.valid;
      if (adv_b) b_v_r <= a_v_r;
      // Load items end at the memory write; only render items go on.
      if (adv_c) c_v_r <= b_v_r && b_r.render;
      if (adv_d) d_v_r <= c_v_r;
      if (adv_e) e_v_r <= d_v_r;
      if (adv_f) f_v_r <= e_v_r;
      if (adv_g) g_v_r <= f_v_r;
      if (adv_h) h_v_r <= g_v_r;
      if (adv_o) o_v_r <= h_v_r;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (adv_a) a_r <= a_nxt;
    if (adv_b) b_r <= b_nxt;
    if (adv_c) c_r <= c_nxt;
    if (adv_d) d_r <= d_nxt;
    if (adv_e) e_r <= e_nxt;
    if (adv_f) f_r <= f_nxt;
    if (adv_g) g_r <= g_nxt;
    if (adv_h) h_r <= h_nxt;
    if (adv_o) o_r <= o_nxt;
  end

  // Result channel.
  assign out_ch.valid        = o_v_r;
  assign out_ch.target_index = o_r.target;
  assign out_ch.mix_out      = o_r.mix;
  assign out_ch.in_range     = o_r.inr;
  assign out_ch.saturated    = o_r.sat;

endmodule

// ===== tb/sv/pitched_sample_resample_mixer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitched_sample_resample_mixer_core_tb
// Self-checking testbench for the sample-playback resampling mixer. Load
// transfers fill a shadow copy of the source memory, and every render transfer
// is predicted in the bench: pitch-scaled read position, linear interpolation,
// velocity gain with round-half-away, and a saturating add into the mix. Each
// result is compared field by field, in order, with the oldest prediction.
// Directed cases cover the field extremes, clipping, rounding ties, the memory
// boundary and the source length limits. Random phases then mix loads and
// renders under three idling patterns on both channels.
// ----------------------------------------------------------------------------
module pitched_sample_resample_mixer_core_tb;
  import psrm_pkg::*;

  localparam int               WATCHDOG_LIMIT = 2000;
  localparam int               DRAIN_CYCLES   = 12;
  localparam int               TAIL_CYCLES    = 20;
  localparam int               MEM_FRAMES     = 65536;
  localparam int unsigned      LEN_MAX        = 131071;
  localparam int               POS_SHIFT      = 5;
  localparam int               FRAC_BITS      = 16;
  localparam int               ROOT_NOTE      = 60;
  localparam int               NOTE_MAX       = 127;
  localparam int               VEL_MAX        = 127;
  localparam int unsigned      OFFS_MAX       = 2097151;
  localparam int unsigned      START_MAX      = 16777215;
  localparam longint           MIX_HI         = 8388607;
  localparam longint           MIX_LO         = -8388608;
  localparam longint unsigned  GAIN_DIVISOR   = 16646144;
  localparam longint unsigned  GAIN_ROUND     = 8323072;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_RENDER = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t                 kind;
    logic [INDEX_W-1:0]        src_index;
    logic signed [VALUE_W-1:0] src_value;
    logic [NOTE_W-1:0]         note;
    logic [VEL_W-1:0]          vel;
    logic [START_W-1:0]        start;
    logic [OFFS_W-1:0]         offs;
    logic signed [MIX_W-1:0]   mix;
  } voice_req_t;

  typedef struct {
    logic [TARGET_W-1:0]     target;
    logic signed [MIX_W-1:0] mix;
    logic                    in_range;
    logic                    saturated;
  } mix_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  psrm_in_if  in_ch ();
  psrm_out_if out_ch ();

  pitched_sample_resample_mixer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow of the block state: source memory, which entries hold data, length.
  logic signed [VALUE_W-1:0] src_mem [MEM_FRAMES];
  bit                        src_written [MEM_FRAMES];
  int unsigned               source_len = 0;
  int                        fill_top = 0;

  mix_result_t expected_mix_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          fail_count    = 0;
  int          loads_sent    = 0;
  int          renders_sent  = 0;
  int          reads_seen    = 0;
  int          clips_seen    = 0;
  int          length_writes = 0;
  int          quiet_cycles  = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Semitone ratio 2^(k/12) in Q16.
  function automatic longint unsigned semitone_q16(input int unsigned k);
    case (k)
      0:       return 65536;
      1:       return 69433;
      2:       return 73562;
      3:       return 77936;
      4:       return 82570;
      5:       return 87480;
      6:       return 92682;
      7:       return 98193;
      8:       return 104032;
      9:       return 110218;
      10:      return 116772;
      11:      return 123715;
      default: return 65536;
    endcase
  endfunction

  // Read position in Q16: offset times ratio, octave as a shift, truncated.
  function automatic longint unsigned read_position(input logic [NOTE_W-1:0] note,
                                                    input logic [OFFS_W-1:0] offs);
    longint unsigned scaled;
    scaled = 64'(offs);
    scaled = scaled * semitone_q16(32'(note % 12));
    return (scaled << (note / 12)) >> POS_SHIFT;
  endfunction

  function automatic longint unsigned effective_length();
    return (source_len > MEM_FRAMES) ? 64'(MEM_FRAMES) : 64'(source_len);
  endfunction

  // True when a render reads no source entry that was never loaded.
  function automatic bit reads_known(input voice_req_t r);
    longint unsigned idx;
    idx = read_position(r.note, r.offs) >> FRAC_BITS;
    if (idx + 1 >= effective_length()) return 1'b1;
    return src_written[idx] && src_written[idx + 1];
  endfunction

  // Expected output of one render: interpolate, apply gain, add and clip.
  function automatic mix_result_t predict_mix(input voice_req_t r);
    mix_result_t     res;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned mag;
    longint unsigned quo;
    longint          frac;
    longint          s1;
    longint          s2;
    longint          interp;
    longint          vel_l;
    longint          prod;
    longint          add;
    longint          sum;
    pos           = read_position(r.note, r.offs);
    idx           = pos >> FRAC_BITS;
    frac          = longint'(pos & 64'hFFFF);
    sum           = longint'(r.mix);
    res.in_range  = 1'b0;
    res.saturated = 1'b0;
    if (idx + 1 < effective_length()) begin
      s1     = longint'(src_mem[idx]);
      s2     = longint'(src_mem[idx + 1]);
      interp = s1 * (65536 - frac) + s2 * frac;
      vel_l  = longint'(r.vel);
      prod   = interp * vel_l;
      mag    = (prod < 0) ? -prod : prod;
      quo    = (mag + GAIN_ROUND) / GAIN_DIVISOR;
      add    = (prod < 0) ? -longint'(quo) : longint'(quo);
      sum    = sum + add;
      if (sum > MIX_HI) begin
        sum           = MIX_HI;
        res.saturated = 1'b1;
      end else if (sum < MIX_LO) begin
        sum           = MIX_LO;
        res.saturated = 1'b1;
      end
      res.in_range = 1'b1;
    end
    res.mix    = sum[MIX_W-1:0];
    res.target = TARGET_W'(r.start) + TARGET_W'(r.offs);
    return res;
  endfunction

  // Item builders; fields a request does not use carry random values.
  function automatic voice_req_t make_load(input logic [INDEX_W-1:0] index,
                                           input logic signed [VALUE_W-1:0] value);
    voice_req_t r;
    r.kind      = REQ_LOAD;
    r.src_index = index;
    r.src_value = value;
    r.note      = NOTE_W'($urandom);
    r.vel       = VEL_W'($urandom);
    r.start     = START_W'($urandom);
    r.offs      = OFFS_W'($urandom);
    r.mix       = MIX_W'($urandom);
    return r;
  endfunction

  function automatic voice_req_t make_render(input logic [NOTE_W-1:0] note,
                                             input logic [VEL_W-1:0] vel,
                                             input logic [START_W-1:0] start,
                                             input logic [OFFS_W-1:0] offs,
                                             input logic signed [MIX_W-1:0] mix);
    voice_req_t r;
    r.kind      = REQ_RENDER;
    r.src_index = INDEX_W'($urandom);
    r.src_value = VALUE_W'($urandom);
    r.note      = note;
    r.vel       = vel;
    r.start     = start;
    r.offs      = offs;
    r.mix       = mix;
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [VEL_W-1:0] rand_velocity();
    case ($urandom_range(3))
      0:       return '0;
      1:       return VEL_W'(VEL_MAX);
      default: return VEL_W'($urandom_range(VEL_MAX));
    endcase
  endfunction

  // Mix values lean toward both rails so that clipping happens often.
  function automatic logic signed [MIX_W-1:0] rand_mix_in();
    case ($urandom_range(3))
      0:       return MIX_W'(MIX_HI - longint'($urandom_range(20000)));
      1:       return MIX_W'(MIX_LO + longint'($urandom_range(20000)));
      default: return MIX_W'($urandom);
    endcase
  endfunction

  // Update the shadow state for a transfer and queue the expected result.
  function automatic void accept_item(input voice_req_t item);
    mix_result_t want;
    if (item.kind == REQ_LOAD) begin
      src_mem[item.src_index]     = item.src_value;
      src_written[item.src_index] = 1'b1;
      while (fill_top < MEM_FRAMES && src_written[fill_top]) fill_top++;
      loads_sent++;
    end else begin
      want = predict_mix(item);
      expected_mix_q.push_back(want);
      renders_sent++;
      if (want.in_range) reads_seen++;
      if (want.saturated) clips_seen++;
    end
  endfunction

  // Present one item, idling at random first, and hold it until the transfer.
  task automatic send_item(input voice_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= item.kind;
    in_ch.source_index   <= item.src_index;
    in_ch.source_value   <= item.src_value;
    in_ch.pitch_note     <= item.note;
    in_ch.velocity       <= item.vel;
    in_ch.start_position <= item.start;
    in_ch.sample_offset  <= item.offs;
    in_ch.mix_in         <= item.mix;
    do @(posedge clk); while (!in_ch.ready);
    accept_item(item);
  endtask

  task automatic send_render(input int note, input int vel, input int unsigned start,
                             input int unsigned offs, input longint mix);
    send_item(make_render(NOTE_W'(note), VEL_W'(vel), START_W'(start), OFFS_W'(offs),
                          MIX_W'(mix)));
  endtask

  // Random render; most aim inside the loaded region, the rest anywhere.
  task automatic pick_render(input bit aim_inside, output voice_req_t r);
    longint unsigned   limit;
    longint unsigned   ratio_shifted;
    longint unsigned   omax;
    logic [NOTE_W-1:0] note;
    logic [OFFS_W-1:0] offs;
    int                tries;
    bit                ok;
    ok    = 1'b0;
    tries = 0;
    limit = effective_length();
    if (fill_top < limit) limit = 64'(fill_top);
    while (!ok && tries < 64) begin
      note = NOTE_W'($urandom_range(NOTE_MAX));
      if (aim_inside) begin
        ratio_shifted = semitone_q16(32'(note % 12)) << (note / 12);
        omax          = (limit << (FRAC_BITS + POS_SHIFT)) / ratio_shifted;
        if (omax > OFFS_MAX) omax = OFFS_MAX;
        offs = OFFS_W'($urandom_range(32'(omax)));
      end else begin
        offs = OFFS_W'($urandom);
      end
      r     = make_render(note, rand_velocity(), START_W'($urandom), offs, rand_mix_in());
      ok    = reads_known(r);
      tries = tries + 1;
    end
    // Highest pitch at the largest offset always lands past the memory.
    if (!ok) begin
      r.note = NOTE_W'(NOTE_MAX);
      r.offs = OFFS_W'(OFFS_MAX);
    end
  endtask

  // Drop valid and wait at least one edge, then until every result is back.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_mix_q.size() != 0);
  endtask

  // Length changes only with the pipeline empty, loads included.
  task automatic write_source_length(input int unsigned len);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LEN_W'(len);
    @(posedge clk);
    cfg_we     <= 1'b0;
    source_len = len;
    length_writes++;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // After reset the length is zero, so every render passes the mix through.
  task automatic test_reset_state();
    send_render(0, 0, 0, 0, MIX_LO);
    send_render(NOTE_MAX, VEL_MAX, START_MAX, OFFS_MAX, MIX_HI);
  endtask

  // Clipping both ways, rounding ties, interpolation and the memory top end.
  task automatic test_directed_extremes();
    send_item(make_load(INDEX_W'(0), 16'sh7FFF));
    send_item(make_load(INDEX_W'(1), 16'sh7FFF));
    send_item(make_load(INDEX_W'(2), 16'sh8000));
    send_item(make_load(INDEX_W'(3), 16'sh8000));
    send_item(make_load(INDEX_W'(4), VALUE_W'(1)));
    send_item(make_load(INDEX_W'(5), VALUE_W'(1)));
    send_item(make_load(INDEX_W'(6), VALUE_W'(-1)));
    send_item(make_load(INDEX_W'(7), VALUE_W'(-1)));
    send_item(make_load(INDEX_W'(8), VALUE_W'(-12345)));
    send_item(make_load(INDEX_W'(MEM_FRAMES - 2), VALUE_W'(12000)));
    send_item(make_load(INDEX_W'(MEM_FRAMES - 1), VALUE_W'(-20000)));
    write_source_length(MEM_FRAMES);
    send_render(ROOT_NOTE, VEL_MAX, 0, 0, MIX_HI);
    send_render(ROOT_NOTE, VEL_MAX, START_MAX, 2, MIX_LO);
    send_render(ROOT_NOTE, 0, 12345, 1, 0);
    send_render(ROOT_NOTE - 12, VEL_MAX, 77, 3, 0);
    send_render(ROOT_NOTE, VEL_MAX, 5, 4, 100);
    send_render(ROOT_NOTE, VEL_MAX, 6, 6, -100);
    send_render(ROOT_NOTE + 12, 64, 1000, 1, -5000);
    send_render(ROOT_NOTE + 1, 100, 999, 7, 4000000);
    send_render(ROOT_NOTE, VEL_MAX, START_MAX, MEM_FRAMES - 2, -4000000);
    send_render(ROOT_NOTE, VEL_MAX, 42, MEM_FRAMES - 1, 321);
    send_render(0, VEL_MAX, START_MAX, OFFS_MAX, -1);
    send_render(NOTE_MAX, VEL_MAX, 0, 0, 1);
  endtask

  // A length past the memory is capped; lengths 0 and 1 leave no pair to read.
  task automatic test_length_limits();
    write_source_length(LEN_MAX);
    send_render(ROOT_NOTE, VEL_MAX, 10, MEM_FRAMES - 2, 0);
    write_source_length(0);
    send_render(ROOT_NOTE, VEL_MAX, 11, 0, 0);
    write_source_length(1);
    send_render(ROOT_NOTE, VEL_MAX, 12, 0, 0);
    write_source_length(2);
    send_render(ROOT_NOTE, VEL_MAX, 13, 0, 0);
    send_render(ROOT_NOTE, VEL_MAX, 14, 1, 0);
  endtask

  // Fill a region, then a random mix of renders and stray loads; the sender
  // holds off halfway until every pending result is back.
  task automatic test_random_mix(input int unsigned len, input int first_load,
                                 input int last_load, input bit load_top, input int items);
    voice_req_t r;
    int         pick;
    write_source_length(len);
    for (int a = first_load; a <= last_load; a++)
      send_item(make_load(INDEX_W'(a), rand_sample()));
    if (load_top) begin
      for (int a = MEM_FRAMES - 8; a < MEM_FRAMES; a++)
        send_item(make_load(INDEX_W'(a), rand_sample()));
    end
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) wait_results_drained();
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(make_load(INDEX_W'($urandom_range(fill_top + 8)), rand_sample()));
      end else if (pick < 10) begin
        send_item(make_load(INDEX_W'($urandom), rand_sample()));
      end else if (pick < 15) begin
        // Reads near the top of the memory, across the last valid pair.
        r = make_render(NOTE_W'(ROOT_NOTE), rand_velocity(), START_W'($urandom),
                        OFFS_W'(MEM_FRAMES - 1 - $urandom_range(7)), rand_mix_in());
        if (!reads_known(r)) r.offs = OFFS_W'(OFFS_MAX);
        send_item(r);
      end else begin
        pick_render(pick < 80, r);
        send_item(r);
      end
    end
  endtask

  task automatic finish_run();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d loads and %0d renders; %0d read source pairs, %0d clipped.",
             loads_sent, renders_sent, reads_seen, clips_seen);
    $display("Source length set %0d times between 0 and %0d under three idling patterns.",
             length_writes, LEN_MAX);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic check_mix_result();
    mix_result_t want;
    if (expected_mix_q.size() == 0) begin
      $error("result with no render pending: target_index %0d mix_out %0d",
             out_ch.target_index, out_ch.mix_out);
      fail_count++;
    end else begin
      want = expected_mix_q.pop_front();
      if (out_ch.target_index !== want.target) begin
        $error("target_index: expected %0d, got %0d", want.target, out_ch.target_index);
        fail_count++;
      end
      if (out_ch.mix_out !== want.mix) begin
        $error("mix_out: expected %0d, got %0d", want.mix, out_ch.mix_out);
        fail_count++;
      end
      if (out_ch.in_range !== want.in_range) begin
        $error("in_range: expected %0b, got %0b", want.in_range, out_ch.in_range);
        fail_count++;
      end
      if (out_ch.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, out_ch.saturated);
        fail_count++;
      end
    end
  endtask

  // Result side: check each transfer, then stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_mix_result();
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = REQ_LOAD;
    in_ch.source_index   = '0;
    in_ch.source_value   = '0;
    in_ch.pitch_note     = '0;
    in_ch.velocity       = '0;
    in_ch.start_position = '0;
    in_ch.sample_offset  = '0;
    in_ch.mix_in         = '0;
    set_idling(26, 80);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_extremes();
    test_length_limits();
    test_random_mix(48, 9, 39, 1'b0, 140);
    set_idling(80, 26);
    test_random_mix(LEN_MAX, 40, 119, 1'b1, 140);
    set_idling(0, 0);
    test_random_mix(100, 120, 119, 1'b0, 220);
    finish_run();
  end

endmodule
